// ----- src/gtu_pkg.sv -----
// Shared types, constants and tables for the GPS to UTC calendar converter.
package gtu_pkg;

    localparam int NumLeapsDefault = 16;
    localparam int LeapTableLen = 16;
    localparam int SecPerDay = 86400;

    localparam int CntW = 5;
    localparam int UnixW = 32;
    localparam int DayW = 15;
    localparam int SodW = 17;

    localparam logic [UnixW-1:0] UnixGpsOffset = 32'd315964800;

    localparam logic [30:0] LeapInstant [LeapTableLen] = '{
        31'((361 + 0 * 365 + 0 + 181) * SecPerDay + 0),
        31'((361 + 1 * 365 + 0 + 181) * SecPerDay + 1),
        31'((361 + 2 * 365 + 0 + 181) * SecPerDay + 2),
        31'((361 + 4 * 365 + 1 + 181) * SecPerDay + 3),
        31'((361 + 7 * 365 + 1) * SecPerDay + 4),
        31'((361 + 9 * 365 + 2) * SecPerDay + 5),
        31'((361 + 10 * 365 + 2) * SecPerDay + 6),
        31'((361 + 11 * 365 + 3 + 181) * SecPerDay + 7),
        31'((361 + 12 * 365 + 3 + 181) * SecPerDay + 8),
        31'((361 + 13 * 365 + 3 + 181) * SecPerDay + 9),
        31'((361 + 15 * 365 + 3) * SecPerDay + 10),
        31'((361 + 16 * 365 + 4 + 181) * SecPerDay + 11),
        31'((361 + 18 * 365 + 4) * SecPerDay + 12),
        31'((361 + 25 * 365 + 6) * SecPerDay + 13),
        31'((361 + 28 * 365 + 7) * SecPerDay + 14),
        31'((361 + 31 * 365 + 8 + 181) * SecPerDay + 15)
    };

    // Reciprocal multipliers; each quotient is exact over the range it sees.
    localparam longint DayDivisor = 675;
    localparam logic [25:0] DayMul = 26'((64'd1 << 35) / DayDivisor + 1);
    localparam logic [19:0] CycMul = 20'((64'd1 << 30) / 1461 + 1);
    localparam logic [13:0] HourMul = 14'((64'd1 << 21) / 225 + 1);
    localparam logic [10:0] MinMul = 11'((64'd1 << 14) / 15 + 1);

    localparam int DaysPerCycle = 1461;
    localparam int DaysPerYear = 365;
    localparam int BaseYear = 1969;
    localparam int SecPerHour = 3600;
    localparam int SecPerMin = 60;
    localparam int LeapSecondMark = 60;

    localparam int MonthStart [12] = '{0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334};

    typedef struct packed {
        logic        valid;
        logic        at_leap;
        logic [29:0] nsec;
    } gtu_side_t;

endpackage

// ----- src/gtu_leap.sv -----
// Leap-second table lookup and conversion to Unix seconds (two stages).
module gtu_leap #(
    parameter int NUM_LEAPS = gtu_pkg::NumLeapsDefault
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  logic [30:0]             gps_second,
    input  logic [29:0]             gps_nanosecond,
    output gtu_pkg::gtu_side_t      side,
    output logic [gtu_pkg::UnixW-1:0] unix_sec
);
    import gtu_pkg::*;

    localparam int Used = (NUM_LEAPS > LeapTableLen) ? LeapTableLen : NUM_LEAPS;

    logic [CntW-1:0]  count_next;
    logic [CntW-1:0]  count_reg;
    logic [30:0]      gps_reg;
    gtu_side_t        side1_next;
    gtu_side_t        side1_reg;
    gtu_side_t        side2_reg;
    logic [UnixW-1:0] unix_next;
    logic [UnixW-1:0] unix_reg;

    always_comb
    begin
        count_next = '0;
        side1_next.valid = start;
        side1_next.at_leap = 1'b0;
        side1_next.nsec = gps_nanosecond;
        for (int i = 0; i < LeapTableLen; i++)
        begin
            if (i < Used)
            begin
                if (gps_second >= LeapInstant[i])
                begin
                    count_next = CntW'(i + 1);
                end
                if (gps_second == LeapInstant[i])
                begin
                    side1_next.at_leap = 1'b1;
                end
            end
        end
    end

    always_comb
    begin
        unix_next = UnixW'(gps_reg) + UnixGpsOffset - UnixW'(count_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            side1_reg <= '0;
            side2_reg <= '0;
        end
        else
        begin
            side1_reg <= side1_next;
            side2_reg <= side1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        gps_reg <= gps_second;
        count_reg <= count_next;
        unix_reg <= unix_next;
    end

    assign side = side2_reg;
    assign unix_sec = unix_reg;

    a_leap_counted: assert property (@(posedge clk) disable iff (!rst_n)
        side1_reg.valid && side1_reg.at_leap |-> count_reg != '0)
        else $error("leap second flagged with no table entry counted");

endmodule

// ----- src/gtu_split.sv -----
// Split of Unix seconds into whole days and second of day (two stages).
module gtu_split (
    input  logic                      clk,
    input  logic                      rst_n,
    input  gtu_pkg::gtu_side_t        side_in,
    input  logic [gtu_pkg::UnixW-1:0] unix_sec,
    output gtu_pkg::gtu_side_t        side_out,
    output logic [gtu_pkg::DayW-1:0]  days,
    output logic [gtu_pkg::SodW-1:0]  sod
);
    import gtu_pkg::*;

    logic [24:0]     x_reg;
    logic [6:0]      low_reg;
    logic [50:0]     prod_next;
    logic [50:0]     prod_reg;
    gtu_side_t       side3_reg;
    gtu_side_t       side4_reg;
    logic [DayW-1:0] days_next;
    logic [DayW-1:0] days_reg;
    logic [9:0]      rem_next;
    logic [SodW-1:0] sod_next;
    logic [SodW-1:0] sod_reg;

    always_comb
    begin
        prod_next = 51'(unix_sec[UnixW-1:7]) * 51'(DayMul);
    end

    always_comb
    begin
        days_next = prod_reg[49:35];
        rem_next = 10'(x_reg - 25'(days_next) * 25'(DayDivisor));
        sod_next = {rem_next, low_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            side3_reg <= '0;
            side4_reg <= '0;
        end
        else
        begin
            side3_reg <= side_in;
            side4_reg <= side3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg <= unix_sec[UnixW-1:7];
        low_reg <= unix_sec[6:0];
        prod_reg <= prod_next;
        days_reg <= days_next;
        sod_reg <= sod_next;
    end

    assign side_out = side4_reg;
    assign days = days_reg;
    assign sod = sod_reg;

    a_sod_range: assert property (@(posedge clk) disable iff (!rst_n)
        side4_reg.valid |-> sod_reg < SodW'(SecPerDay))
        else $error("second of day out of range");

endmodule

// ----- src/gtu_civil.sv -----
// Day count to calendar date and second of day to time of day (four stages).
module gtu_civil (
    input  logic                     clk,
    input  logic                     rst_n,
    input  gtu_pkg::gtu_side_t       side_in,
    input  logic [gtu_pkg::DayW-1:0] days,
    input  logic [gtu_pkg::SodW-1:0] sod,
    output logic                     done,
    output logic [11:0]              utc_year,
    output logic [3:0]               utc_month,
    output logic [4:0]               utc_day,
    output logic [4:0]               utc_hour,
    output logic [5:0]               utc_minute,
    output logic [5:0]               utc_second,
    output logic [29:0]              utc_nanosecond
);
    import gtu_pkg::*;

    gtu_side_t       side5_reg;
    gtu_side_t       side6_reg;
    gtu_side_t       side7_reg;
    gtu_side_t       side8_reg;

    logic [DayW-1:0] d_next;
    logic [DayW-1:0] d_reg;
    logic [34:0]     prodb_next;
    logic [34:0]     prodb_reg;
    logic [26:0]     prodh_next;
    logic [26:0]     prodh_reg;
    logic [SodW-1:0] sod5_reg;

    logic [4:0]      cyc_next;
    logic [4:0]      cyc_reg;
    logic [10:0]     r_next;
    logic [10:0]     r_reg;
    logic [4:0]      hour_next;
    logic [4:0]      hour6_reg;
    logic [11:0]     rem_next;
    logic [11:0]     rem6_reg;

    logic [1:0]      y_next;
    logic [8:0]      doy_next;
    logic [8:0]      doy_reg;
    logic            leap_next;
    logic            leap_reg;
    logic [11:0]     year_next;
    logic [11:0]     year7_reg;
    logic [20:0]     prodm_next;
    logic [20:0]     prodm_reg;
    logic [4:0]      hour7_reg;
    logic [11:0]     rem7_reg;

    logic [3:0]      month_next;
    logic [8:0]      mstart;
    logic [8:0]      mbound;
    logic [4:0]      day_next;
    logic [5:0]      minute_next;
    logic [5:0]      second_next;

    logic [11:0]     year_reg;
    logic [3:0]      month_reg;
    logic [4:0]      day_reg;
    logic [4:0]      hour_reg;
    logic [5:0]      minute_reg;
    logic [5:0]      second_reg;

    always_comb
    begin
        d_next = days + DayW'(DaysPerYear);
        prodb_next = 35'(d_next) * 35'(CycMul);
        prodh_next = 27'(sod[SodW-1:4]) * 27'(HourMul);
    end

    always_comb
    begin
        cyc_next = prodb_reg[34:30];
        r_next = 11'(d_reg - DayW'(cyc_next) * DayW'(DaysPerCycle));
        hour_next = prodh_reg[25:21];
        rem_next = 12'(sod5_reg - SodW'(hour_next) * SodW'(SecPerHour));
    end

    always_comb
    begin
        if (r_reg >= 11'(3 * DaysPerYear))
        begin
            y_next = 2'd3;
        end
        else if (r_reg >= 11'(2 * DaysPerYear))
        begin
            y_next = 2'd2;
        end
        else if (r_reg >= 11'(DaysPerYear))
        begin
            y_next = 2'd1;
        end
        else
        begin
            y_next = 2'd0;
        end
        doy_next = 9'(r_reg - 11'(y_next) * 11'(DaysPerYear));
        leap_next = (y_next == 2'd3);
        year_next = 12'(BaseYear) + 12'(cyc_reg) * 12'd4 + 12'(y_next);
        prodm_next = 21'(rem6_reg[11:2]) * 21'(MinMul);
    end

    always_comb
    begin
        month_next = 4'd1;
        mstart = '0;
        for (int m = 1; m < 12; m++)
        begin
            mbound = 9'(MonthStart[m]) + ((m >= 2 && leap_reg) ? 9'd1 : 9'd0);
            if (doy_reg >= mbound)
            begin
                month_next = 4'(m + 1);
                mstart = mbound;
            end
        end
        day_next = 5'(doy_reg - mstart + 9'd1);
        minute_next = prodm_reg[19:14];
        if (side7_reg.at_leap)
        begin
            second_next = 6'(LeapSecondMark);
        end
        else
        begin
            second_next = 6'(rem7_reg - 12'(minute_next) * 12'(SecPerMin));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            side5_reg <= '0;
            side6_reg <= '0;
            side7_reg <= '0;
            side8_reg <= '0;
        end
        else
        begin
            side5_reg <= side_in;
            side6_reg <= side5_reg;
            side7_reg <= side6_reg;
            side8_reg <= side7_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        d_reg <= d_next;
        prodb_reg <= prodb_next;
        prodh_reg <= prodh_next;
        sod5_reg <= sod;
        cyc_reg <= cyc_next;
        r_reg <= r_next;
        hour6_reg <= hour_next;
        rem6_reg <= rem_next;
        doy_reg <= doy_next;
        leap_reg <= leap_next;
        year7_reg <= year_next;
        prodm_reg <= prodm_next;
        hour7_reg <= hour6_reg;
        rem7_reg <= rem6_reg;
        year_reg <= year7_reg;
        month_reg <= month_next;
        day_reg <= day_next;
        hour_reg <= hour7_reg;
        minute_reg <= minute_next;
        second_reg <= second_next;
    end

    assign done = side8_reg.valid;
    assign utc_year = year_reg;
    assign utc_month = month_reg;
    assign utc_day = day_reg;
    assign utc_hour = hour_reg;
    assign utc_minute = minute_reg;
    assign utc_second = second_reg;
    assign utc_nanosecond = side8_reg.nsec;

    a_month_range: assert property (@(posedge clk) disable iff (!rst_n)
        side8_reg.valid |-> month_reg >= 4'd1 && month_reg <= 4'd12 && day_reg != '0)
        else $error("calendar month or day out of range");

    a_second_range: assert property (@(posedge clk) disable iff (!rst_n)
        side8_reg.valid && !side8_reg.at_leap |-> second_reg < 6'(SecPerMin))
        else $error("second out of range outside a leap second");

endmodule

// ----- src/gps_to_utc_calendar.sv -----
// Top level of the GPS time to UTC calendar converter.
//
// A GPS timestamp (seconds since 6 January 1980 and nanoseconds) is taken as a
// beat whenever start is high and busy is low. busy is never raised, so a new
// beat may be offered in every cycle.
// Each beat is converted to a UTC date and time of day, with the accumulated
// leap seconds taken from a fixed table. On an inserted leap second the second
// reads 60. Nanoseconds are passed through unchanged.
// The result appears on the utc_* ports for one cycle with done high, after
// passing through two stages for the table lookup and offset, two for the
// division into days, and four for the date and time split.
// Throughput is one beat per cycle; results leave in the order beats entered.
// The receiver cannot stall the output, so no result is held back.
// Reset clears the valid bits of every stage; beats in flight are dropped.
module gps_to_utc_calendar #(
    parameter int NUM_LEAPS = gtu_pkg::NumLeapsDefault
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [30:0] gps_second,
    input  logic [29:0] gps_nanosecond,
    output logic        done,
    output logic [11:0] utc_year,
    output logic [3:0]  utc_month,
    output logic [4:0]  utc_day,
    output logic [4:0]  utc_hour,
    output logic [5:0]  utc_minute,
    output logic [5:0]  utc_second,
    output logic [29:0] utc_nanosecond
);
    import gtu_pkg::*;

    gtu_side_t        side_a;
    gtu_side_t        side_b;
    logic [UnixW-1:0] unix_sec;
    logic [DayW-1:0]  days;
    logic [SodW-1:0]  sod;

    assign busy = 1'b0;

    gtu_leap #(
        .NUM_LEAPS(NUM_LEAPS)
    ) u_leap (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .gps_second(gps_second),
        .gps_nanosecond(gps_nanosecond),
        .side(side_a),
        .unix_sec(unix_sec)
    );

    gtu_split u_split (
        .clk(clk),
        .rst_n(rst_n),
        .side_in(side_a),
        .unix_sec(unix_sec),
        .side_out(side_b),
        .days(days),
        .sod(sod)
    );

    gtu_civil u_civil (
        .clk(clk),
        .rst_n(rst_n),
        .side_in(side_b),
        .days(days),
        .sod(sod),
        .done(done),
        .utc_year(utc_year),
        .utc_month(utc_month),
        .utc_day(utc_day),
        .utc_hour(utc_hour),
        .utc_minute(utc_minute),
        .utc_second(utc_second),
        .utc_nanosecond(utc_nanosecond)
    );

endmodule
